/* sv/a2i_pkg.sv */
// package: word widths and request/response word types for the affine inverse
`timescale 1ns / 1ps
package a2i_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] m00_in;
      logic signed [WORD_BITS-1:0] m10_in;
      logic signed [WORD_BITS-1:0] m01_in;
      logic signed [WORD_BITS-1:0] m11_in;
      logic signed [WORD_BITS-1:0] shift_x_in;
      logic signed [WORD_BITS-1:0] shift_y_in;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] m00_out;
      logic signed [WORD_BITS-1:0] m10_out;
      logic signed [WORD_BITS-1:0] m01_out;
      logic signed [WORD_BITS-1:0] m11_out;
      logic signed [WORD_BITS-1:0] shift_x_out;
      logic signed [WORD_BITS-1:0] shift_y_out;
      logic                        singular;
      logic                        saturated;
   } rsp_type;

endpackage

/* sv/affine_2d_inverse.sv */
// top level: pipelined inverse of a 2d affine transform in signed fixed point
// throughput: one word per cycle unless the output stalls; the restoring divider
// gives one quotient bit per stage, so its WORD_BITS + 1 stages set the depth
// each stage moves on when the next one is empty or moving, so bubbles collapse
// reset: synchronous, clears the stage valid bits only; datapath is not reset
`timescale 1ns / 1ps
module affine_2d_inverse
   import a2i_pkg::*;
#(
   parameter int FRAC_BITS_P = FRAC_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS_P;
   localparam int DW = 2 * W;        // determinant magnitude width
   localparam int NW = W + 2 * F;    // scaled numerator width
   localparam int QB = W + 1;        // quotient bits kept before clamping
   localparam int NS = QB + 6;       // pipeline stages

   // stage a: the two determinant products
   typedef struct packed {
      logic signed [DW-1:0] p_ad;
      logic signed [DW-1:0] p_bc;
      logic signed [W-1:0]  m00;
      logic signed [W-1:0]  m10;
      logic signed [W-1:0]  m01;
      logic signed [W-1:0]  m11;
      logic signed [W-1:0]  sx;
      logic signed [W-1:0]  sy;
   } a_type;

   // stage b: determinant magnitude and the four numerators in sign/magnitude
   typedef struct packed {
      logic [DW-1:0]        dmag;
      logic                 sing;
      logic [3:0]           neg;
      logic [3:0][W-1:0]    mag;
      logic signed [W-1:0]  sx;
      logic signed [W-1:0]  sy;
   } b_type;

   // divider stages: four lanes share one divisor
   typedef struct packed {
      logic [3:0][DW-1:0]   rem;
      logic [3:0][W-1:0]    mag;
      logic [3:0][QB-1:0]   q;
      logic [3:0]           neg;
      logic [3:0]           ovf;
      logic [DW-1:0]        dmag;
      logic                 sing;
      logic signed [W-1:0]  sx;
      logic signed [W-1:0]  sy;
   } div_type;

   // stage e: rounded and clamped linear words
   typedef struct packed {
      logic [3:0][W-1:0]    w;
      logic                 sat;
      logic                 sing;
      logic signed [W-1:0]  sx;
      logic signed [W-1:0]  sy;
   } e_type;

   // stage g: translation products
   typedef struct packed {
      logic [3:0][W-1:0]    w;
      logic signed [DW-1:0] px0;
      logic signed [DW-1:0] px1;
      logic signed [DW-1:0] py0;
      logic signed [DW-1:0] py1;
      logic                 sat;
      logic                 sing;
   } g_type;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   a_type   a_ff, a_in;
   b_type   b_ff, b_in;
   div_type div_ff [0:QB];
   div_type div_in [0:QB];
   e_type   e_ff, e_in;
   g_type   g_ff, g_in;
   rsp_type h_ff, h_in;

   // stall chain from the output back to the input
   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NS-1];
   assign rsp_data  = h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // stage a: products straight from the input word
   always_comb begin
      a_in.p_ad = req_data.m00_in * req_data.m11_in;
      a_in.p_bc = req_data.m10_in * req_data.m01_in;
      a_in.m00  = req_data.m00_in;
      a_in.m10  = req_data.m10_in;
      a_in.m01  = req_data.m01_in;
      a_in.m11  = req_data.m11_in;
      a_in.sx   = req_data.shift_x_in;
      a_in.sy   = req_data.shift_y_in;
   end

   // stage b: exact determinant, its sign and the adjugate numerators
   logic signed [DW:0] det;
   logic               dneg;
   always_comb begin
      det       = {a_ff.p_ad[DW-1], a_ff.p_ad} - {a_ff.p_bc[DW-1], a_ff.p_bc};
      dneg      = det[DW];
      b_in.dmag = dneg ? DW'(~det + 1'b1) : DW'(det);
      b_in.sing = (det == '0);
      // lane order: m00_out, m10_out, m01_out, m11_out
      b_in.mag[0] = a_ff.m11[W-1] ? (~a_ff.m11 + 1'b1) : a_ff.m11;
      b_in.mag[1] = a_ff.m10[W-1] ? (~a_ff.m10 + 1'b1) : a_ff.m10;
      b_in.mag[2] = a_ff.m01[W-1] ? (~a_ff.m01 + 1'b1) : a_ff.m01;
      b_in.mag[3] = a_ff.m00[W-1] ? (~a_ff.m00 + 1'b1) : a_ff.m00;
      b_in.neg[0] = a_ff.m11[W-1] ^ dneg;
      b_in.neg[1] = !a_ff.m10[W-1] ^ dneg;
      b_in.neg[2] = !a_ff.m01[W-1] ^ dneg;
      b_in.neg[3] = a_ff.m00[W-1] ^ dneg;
      b_in.sx     = a_ff.sx;
      b_in.sy     = a_ff.sy;
   end

   // divider entry: top numerator bits form the first remainder, and a
   // quotient that needs more than QB bits is flagged as overflow
   // then the restoring divider, one quotient bit per stage
   always_comb begin
      logic [NW-1:0]  num;
      logic [2*F-2:0] top;
      logic [DW:0]    t;
      for (int l = 0; l < 4; l++) begin
         num               = {b_ff.mag[l], {(2*F){1'b0}}};
         top               = num[NW-1:QB];
         div_in[0].ovf[l]  = DW'(top) >= b_ff.dmag;
         div_in[0].rem[l]  = DW'(top);
         div_in[0].q[l]    = '0;
      end
      div_in[0].mag  = b_ff.mag;
      div_in[0].neg  = b_ff.neg;
      div_in[0].dmag = b_ff.dmag;
      div_in[0].sing = b_ff.sing;
      div_in[0].sx   = b_ff.sx;
      div_in[0].sy   = b_ff.sy;
      for (int k = 1; k <= QB; k++) begin
         div_in[k] = div_ff[k-1];
         for (int l = 0; l < 4; l++) begin
            num = {div_ff[k-1].mag[l], {(2*F){1'b0}}};
            t   = {div_ff[k-1].rem[l], num[QB-k]};
            if (t >= {1'b0, div_ff[k-1].dmag}) begin
               div_in[k].rem[l] = DW'(t - {1'b0, div_ff[k-1].dmag});
               div_in[k].q[l]   = {div_ff[k-1].q[l][QB-2:0], 1'b1};
            end else begin
               div_in[k].rem[l] = DW'(t);
               div_in[k].q[l]   = {div_ff[k-1].q[l][QB-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) a_ff <= a_in;
      if (en[1]) b_ff <= b_in;
      for (int k = 0; k <= QB; k++) begin
         if (en[2+k]) div_ff[k] <= div_in[k];
      end
   end

   // stage e: round half away from zero, clamp to the word range, apply sign
   always_comb begin
      logic [QB:0] qr;
      logic [QB:0] lim;
      logic [QB:0] m;
      logic        over;
      e_in.sat = 1'b0;
      for (int l = 0; l < 4; l++) begin
         qr   = {1'b0, div_ff[QB].q[l]} +
                (({div_ff[QB].rem[l], 1'b0} >= {1'b0, div_ff[QB].dmag}) ? 1'b1 : 1'b0);
         lim  = div_ff[QB].neg[l] ? ((QB+1)'(1) << (W-1))
                                  : (((QB+1)'(1) << (W-1)) - 1'b1);
         over = div_ff[QB].ovf[l] || (qr > lim);
         m    = over ? lim : qr;
         e_in.w[l] = div_ff[QB].neg[l] ? (~m[W-1:0] + 1'b1) : m[W-1:0];
         e_in.sat  = e_in.sat | over;
      end
      e_in.sing = div_ff[QB].sing;
      e_in.sx   = div_ff[QB].sx;
      e_in.sy   = div_ff[QB].sy;
   end

   // stage g: new linear part times old translation
   always_comb begin
      g_in.w    = e_ff.w;
      g_in.px0  = $signed(e_ff.w[0]) * e_ff.sx;
      g_in.px1  = $signed(e_ff.w[2]) * e_ff.sy;
      g_in.py0  = $signed(e_ff.w[1]) * e_ff.sx;
      g_in.py1  = $signed(e_ff.w[3]) * e_ff.sy;
      g_in.sat  = e_ff.sat;
      g_in.sing = e_ff.sing;
   end

   // stage h: exact sums, rounding, negation through the sign and clamping
   always_comb begin
      logic signed [DW:0] s [2];
      logic [DW:0] mag;
      logic [DW:0] r;
      logic [DW:0] lim;
      logic [DW:0] m;
      logic        ns;
      logic        over;
      logic [1:0]  tsat;
      logic [1:0][W-1:0] tw;
      s[0] = {g_ff.px0[DW-1], g_ff.px0} + {g_ff.px1[DW-1], g_ff.px1};
      s[1] = {g_ff.py0[DW-1], g_ff.py0} + {g_ff.py1[DW-1], g_ff.py1};
      for (int l = 0; l < 2; l++) begin
         ns   = s[l][DW];
         mag  = ns ? (~s[l] + 1'b1) : s[l];
         r    = (mag + ((DW+1)'(1) << (F-1))) >> F;
         // result is the negated sum, so a positive sum gives a negative word
         lim  = !ns ? ((DW+1)'(1) << (W-1)) : (((DW+1)'(1) << (W-1)) - 1'b1);
         over = r > lim;
         m    = over ? lim : r;
         tw[l]   = !ns ? (~m[W-1:0] + 1'b1) : m[W-1:0];
         tsat[l] = over;
      end
      if (g_ff.sing) begin
         h_in = '0;
         h_in.singular = 1'b1;
      end else begin
         h_in.m00_out     = g_ff.w[0];
         h_in.m10_out     = g_ff.w[1];
         h_in.m01_out     = g_ff.w[2];
         h_in.m11_out     = g_ff.w[3];
         h_in.shift_x_out = tw[0];
         h_in.shift_y_out = tw[1];
         h_in.singular    = 1'b0;
         h_in.saturated   = g_ff.sat | tsat[0] | tsat[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[QB+3]) e_ff <= e_in;
      if (en[QB+4]) g_ff <= g_in;
      if (en[QB+5]) h_ff <= h_in;
   end

endmodule
